// ===== rtl/core/lse_pkg.sv =====
`timescale 1ns / 1ps

package lse_pkg;

  // Length field size in carrier bytes (one bit per byte), 8..32.
  localparam int unsigned LenBits = 32;
  localparam int unsigned LenIdxW = $clog2(LenBits);

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [15:0] HdrLenRst = 16'd122;
  localparam logic [7:0]  RsvLenRst = 8'd64;

  localparam logic ModeEmbed   = 1'b0;
  localparam logic ModeExtract = 1'b1;

  localparam logic ActCarrier = 1'b0;
  localparam logic ActPayload = 1'b1;

  localparam logic KindCarrier = 1'b0;
  localparam logic KindPayload = 1'b1;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StNoFit     = 2'd1,
    StUnderrun  = 2'd2,
    StOverflow  = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode    = 3'd0,
    CfgHdrLen  = 3'd1,
    CfgPayLen  = 3'd2,
    CfgCarLen  = 3'd3,
    CfgRsvLen  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        mode;
    logic [15:0] header_length;
    logic [31:0] payload_length;
    logic [31:0] carrier_length;
    logic [7:0]  reserved_length;
  } cfg_t;

  // Capacity check: len < 2**LenBits and 8*len + header + length field + reserved <= carrier.
  function automatic logic len_fits(input logic [31:0] len, input logic [15:0] hdr,
                                    input logic [7:0] rsv, input logic [31:0] car);
    logic [35:0] need;
    logic        in_range;
    need     = (36'(len) << 3) + 36'(hdr) + 36'(LenBits) + 36'(rsv);
    in_range = ((36'(len) >> LenBits) == 36'd0);
    return in_range && (need <= 36'(car));
  endfunction

endpackage

// ===== rtl/core/lse_cfg_regs.sv =====
`timescale 1ns / 1ps

module lse_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lse_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [lse_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output lse_pkg::cfg_t                   cfg_o
);

  lse_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        lse_pkg::CfgMode:   cfg_d.mode            = cfg_wdata_i[0];
        lse_pkg::CfgHdrLen: cfg_d.header_length   = cfg_wdata_i[15:0];
        lse_pkg::CfgPayLen: cfg_d.payload_length  = cfg_wdata_i[31:0];
        lse_pkg::CfgCarLen: cfg_d.carrier_length  = cfg_wdata_i[31:0];
        lse_pkg::CfgRsvLen: cfg_d.reserved_length = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode            <= lse_pkg::ModeEmbed;
      cfg_q.header_length   <= lse_pkg::HdrLenRst;
      cfg_q.payload_length  <= 32'd0;
      cfg_q.carrier_length  <= 32'd0;
      cfg_q.reserved_length <= lse_pkg::RsvLenRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/lsb_stego_embed_extract.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Fields
// in       input      in_valid_i/in_ready_o   action_i, data_byte_i
// out      output     out_valid_o/out_ready_i out_byte_o, kind_o, last_o, status_o
// cfg      input      cfg_we_i                cfg_index_i, cfg_wdata_i
//
// One word per cycle while in_ready_o is high: a word is processed in the
// cycle it is accepted, and its result (if any) sits in the output register
// the next cycle. The output register is the only pipeline stage.
// in_ready_o drops only while a result is held and out_ready_i is low.
// Reset clears stream state, the holding register and config to defaults.

module lsb_stego_embed_extract (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lse_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lse_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         action_i,
  input  logic [7:0]                   data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   out_byte_o,
  output logic                         kind_o,
  output logic                         last_o,
  output logic [1:0]                   status_o
);

  lse_pkg::cfg_t cfg;

  lse_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  logic [31:0]                   pos_d, pos_q;
  logic [lse_pkg::LenBits-1:0]   ls_d, ls_q, ls_c, ls_next;
  logic [7:0]                    hold_d, hold_q;
  logic                          hv_d, hv_q;
  logic [2:0]                    bit_d, bit_q, bit_c;
  logic [31:0]                   done_d, done_q, done_c;
  logic [7:0]                    acc_d, acc_q, acc_c;
  logic [1:0]                    ef_d, ef_q, ef_c;

  logic                          out_valid_d, out_valid_q;
  logic [7:0]                    out_byte_q;
  logic                          kind_q, last_q;
  logic [1:0]                    status_q;

  logic                          in_fire;
  logic                          res_valid;
  logic [7:0]                    res_byte;
  logic                          res_kind, res_last;
  logic [1:0]                    res_status;

  logic                          fit_pay, fit_len;
  logic [16:0]                   len_end;
  logic [17:0]                   rsv_end;
  logic                          in_hdr, in_len, in_rsv, len_final;
  logic [lse_pkg::LenIdxW-1:0]   len_off, len_sh;
  logic [31:0]                   pos_inc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign len_end   = {1'b0, cfg.header_length} + 17'(lse_pkg::LenBits);
  assign rsv_end   = {1'b0, len_end} + 18'(cfg.reserved_length);
  assign in_hdr    = pos_q < 32'(cfg.header_length);
  assign in_len    = pos_q < 32'(len_end);
  assign in_rsv    = pos_q < 32'(rsv_end);
  assign len_final = pos_q == (32'(len_end) - 32'd1);
  assign len_off   = lse_pkg::LenIdxW'(pos_q - 32'(cfg.header_length));
  assign len_sh    = lse_pkg::LenIdxW'(lse_pkg::LenBits - 1) - len_off;
  assign pos_inc   = pos_q + 32'd1;

  assign ls_next = {ls_c[lse_pkg::LenBits-2:0], data_byte_i[0]};
  assign fit_pay = lse_pkg::len_fits(cfg.payload_length, cfg.header_length,
                                     cfg.reserved_length, cfg.carrier_length);
  assign fit_len = lse_pkg::len_fits(32'(ls_next), cfg.header_length,
                                     cfg.reserved_length, cfg.carrier_length);

  // stream state as seen by this word; a new stream starts at position zero
  always_comb begin
    ls_c   = ls_q;
    bit_c  = bit_q;
    done_c = done_q;
    acc_c  = acc_q;
    ef_c   = ef_q;
    if (pos_q == 32'd0) begin
      ls_c   = '0;
      bit_c  = 3'd0;
      done_c = 32'd0;
      acc_c  = 8'd0;
      ef_c   = ((cfg.mode == lse_pkg::ModeEmbed) && !fit_pay) ? 2'b01 : 2'b00;
    end
  end

  always_comb begin
    pos_d      = pos_q;
    ls_d       = ls_q;
    hold_d     = hold_q;
    hv_d       = hv_q;
    bit_d      = bit_q;
    done_d     = done_q;
    acc_d      = acc_q;
    ef_d       = ef_q;
    res_valid  = 1'b0;
    res_byte   = 8'd0;
    res_kind   = lse_pkg::KindCarrier;
    res_last   = 1'b0;
    res_status = lse_pkg::StOk;

    if (in_fire) begin
      if (action_i == lse_pkg::ActPayload) begin
        if (cfg.mode == lse_pkg::ModeEmbed) begin
          if (hv_q) begin
            res_valid  = 1'b1;
            res_status = lse_pkg::StOverflow;
          end else begin
            hold_d = data_byte_i;
            hv_d   = 1'b1;
          end
        end
      end else begin
        ls_d   = ls_c;
        bit_d  = bit_c;
        done_d = done_c;
        acc_d  = acc_c;
        ef_d   = ef_c;

        if (cfg.mode == lse_pkg::ModeEmbed) begin
          res_valid = 1'b1;
          res_byte  = data_byte_i;
          if (ef_c[0]) begin
            res_status = lse_pkg::StNoFit;
          end else if (in_hdr) begin
            res_byte = data_byte_i;
          end else if (in_len) begin
            res_byte = {data_byte_i[7:1], cfg.payload_length[len_sh]};
          end else if (in_rsv) begin
            res_byte = data_byte_i;
          end else if (done_c < cfg.payload_length) begin
            if (bit_c == 3'd0) begin
              if (hv_q) begin
                acc_d = hold_q;
                hv_d  = 1'b0;
                ef_d  = ef_c & 2'b01;
              end else begin
                ef_d = ef_c | 2'b10;
              end
            end
            if (ef_d[1]) begin
              res_status = lse_pkg::StUnderrun;
            end else begin
              res_byte = {data_byte_i[7:1], acc_d[3'd7 - bit_c]};
            end
            bit_d = bit_c + 3'd1;
            if (bit_c == 3'd7) begin
              done_d = done_c + 32'd1;
            end
          end
        end else begin
          if (in_hdr) begin
            ls_d = ls_c;
          end else if (in_len) begin
            ls_d = ls_next;
            if (len_final && !fit_len) begin
              ef_d       = ef_c | 2'b01;
              res_valid  = 1'b1;
              res_status = lse_pkg::StNoFit;
            end
          end else if (in_rsv) begin
            ls_d = ls_c;
          end else if (!ef_c[0] && (done_c < 32'(ls_c))) begin
            acc_d = {acc_c[6:0], data_byte_i[0]};
            bit_d = bit_c + 3'd1;
            if (bit_c == 3'd7) begin
              res_valid = 1'b1;
              res_byte  = {acc_c[6:0], data_byte_i[0]};
              res_kind  = lse_pkg::KindPayload;
              res_last  = (done_c + 32'd1) == 32'(ls_c);
              done_d    = done_c + 32'd1;
              acc_d     = 8'd0;
            end
          end
        end

        pos_d = pos_inc;
        if (pos_inc == cfg.carrier_length) begin
          pos_d  = 32'd0;
          ls_d   = '0;
          bit_d  = 3'd0;
          done_d = 32'd0;
          acc_d  = 8'd0;
          ef_d   = 2'b00;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 32'd0;
      ls_q   <= '0;
      hold_q <= 8'd0;
      hv_q   <= 1'b0;
      bit_q  <= 3'd0;
      done_q <= 32'd0;
      acc_q  <= 8'd0;
      ef_q   <= 2'b00;
    end else begin
      pos_q  <= pos_d;
      ls_q   <= ls_d;
      hold_q <= hold_d;
      hv_q   <= hv_d;
      bit_q  <= bit_d;
      done_q <= done_d;
      acc_q  <= acc_d;
      ef_q   <= ef_d;
    end
  end

  // output register: reloads whenever the consumer side is free
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_ready_o) begin
      out_valid_d = in_fire && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_byte_q <= res_byte;
      kind_q     <= res_kind;
      last_q     <= res_last;
      status_q   <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign kind_o      = kind_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

endmodule
